### sv/sqd_pkg.sv
// Package for the sequence-checked packet deframer.
// Item types, length width constants. No dependencies.
`default_nettype none

package sqd_pkg;

  // Width of the internal payload down-counter.
  localparam int unsigned LENGTH_BITS = 24;

  // Width of the header length field as reported.
  localparam int unsigned FIELD_BITS = 24;

  // Header length bits that survive the LENGTH_BITS mask.
  localparam int unsigned LEN_USED = (LENGTH_BITS < FIELD_BITS) ? LENGTH_BITS : FIELD_BITS;
  localparam logic [FIELD_BITS-1:0] LEN_MASK = FIELD_BITS'((64'd1 << LEN_USED) - 64'd1);

  // Header is four bytes: three length bytes, then the sequence byte.
  localparam logic [1:0] SEQ_BYTE_IDX = 2'd3;

  typedef enum logic {
    KIND_STREAM = 1'b0,
    KIND_RESYNC = 1'b1
  } kind_e;

  typedef struct packed {
    logic                  kind;
    logic [7:0]            data_byte;
    logic [7:0]            new_expected_seq;
  } in_item_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  payload_valid;
    logic                  payload_skipped;
    logic                  header_done;
    logic [FIELD_BITS-1:0] packet_length;
    logic [7:0]            packet_seq;
    logic                  protocol_error;
    logic                  last_of_packet;
  } out_item_t;

endpackage

`default_nettype wire

### sv/sqd_if.sv
// Stream channel interfaces of the deframer: input items and result items.
// Depends on sqd_pkg for the length field width.
`default_nettype none

interface sqd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [7:0] new_expected_seq;

  modport source (output valid, output kind, output data_byte, output new_expected_seq,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input new_expected_seq,
                  output ready);
endinterface

interface sqd_out_if;
  logic                             valid;
  logic                             ready;
  logic [7:0]                       out_byte;
  logic                             payload_valid;
  logic                             payload_skipped;
  logic                             header_done;
  logic [sqd_pkg::FIELD_BITS-1:0]   packet_length;
  logic [7:0]                       packet_seq;
  logic                             protocol_error;
  logic                             last_of_packet;

  modport source (output valid, output out_byte, output payload_valid,
                  output payload_skipped, output header_done, output packet_length,
                  output packet_seq, output protocol_error, output last_of_packet,
                  input ready);
  modport sink   (input valid, input out_byte, input payload_valid,
                  input payload_skipped, input header_done, input packet_length,
                  input packet_seq, input protocol_error, input last_of_packet,
                  output ready);
endinterface

`default_nettype wire

### sv/seq_checked_packet_deframer.sv
// A result is registered and appears in the cycle after its input transfer.
// Throughput: one item per cycle; input ready follows the result register
// being empty or taken in the same cycle.
// Reset (rst_ni, async active low): framing at header start, expected
// sequence zero, result register empty.
// Top level of the deframer; depends on sqd_pkg, sqd_if, sqd_core, sqd_out_reg.
`default_nettype none

module seq_checked_packet_deframer (
  input  wire         clk_i,
  input  wire         rst_ni,
  sqd_in_if.sink      in_i,
  sqd_out_if.source   out_o
);

  sqd_pkg::in_item_t  item;
  sqd_pkg::out_item_t result;
  sqd_pkg::out_item_t result_q;
  logic               free;
  logic               accept;
  logic               out_valid;

  assign item.kind             = in_i.kind;
  assign item.data_byte        = in_i.data_byte;
  assign item.new_expected_seq = in_i.new_expected_seq;

  assign in_i.ready = free;
  assign accept     = in_i.valid & free;

  sqd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .result_o (result)
  );

  sqd_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (result),
    .ready_i  (out_o.ready),
    .valid_o  (out_valid),
    .free_o   (free),
    .result_o (result_q)
  );

  assign out_o.valid           = out_valid;
  assign out_o.out_byte        = result_q.out_byte;
  assign out_o.payload_valid   = result_q.payload_valid;
  assign out_o.payload_skipped = result_q.payload_skipped;
  assign out_o.header_done     = result_q.header_done;
  assign out_o.packet_length   = result_q.packet_length;
  assign out_o.packet_seq      = result_q.packet_seq;
  assign out_o.protocol_error  = result_q.protocol_error;
  assign out_o.last_of_packet  = result_q.last_of_packet;

endmodule

`default_nettype wire

### sv/sqd_core.sv
// Framing state and per-byte decode of the deframer.
// Depends on sqd_pkg for item types and length constants.
`default_nettype none

module sqd_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 accept_i,
  input  sqd_pkg::in_item_t   item_i,
  output sqd_pkg::out_item_t  result_o
);

  logic [1:0]                         header_count_q, header_count_d;
  logic [sqd_pkg::FIELD_BITS-1:0]     length_accum_q, length_accum_d;
  logic [sqd_pkg::LENGTH_BITS-1:0]    payload_left_q, payload_left_d;
  logic [7:0]                         expected_seq_q, expected_seq_d;
  logic                               in_sync_q, in_sync_d;

  logic [sqd_pkg::FIELD_BITS-1:0]     len;
  logic [sqd_pkg::FIELD_BITS-1:0]     byte_ext;
  logic                               match;

  assign len      = length_accum_q & sqd_pkg::LEN_MASK;
  assign byte_ext = sqd_pkg::FIELD_BITS'(item_i.data_byte);
  assign match    = (item_i.data_byte == expected_seq_q);

  always_comb begin
    header_count_d = header_count_q;
    length_accum_d = length_accum_q;
    payload_left_d = payload_left_q;
    expected_seq_d = expected_seq_q;
    in_sync_d      = in_sync_q;
    result_o       = '0;

    if (item_i.kind == sqd_pkg::KIND_RESYNC) begin
      expected_seq_d = item_i.new_expected_seq;
    end else begin
      result_o.out_byte = item_i.data_byte;
      if (payload_left_q != '0) begin
        result_o.payload_valid   = in_sync_q;
        result_o.payload_skipped = ~in_sync_q;
        payload_left_d           = payload_left_q - sqd_pkg::LENGTH_BITS'(1);
        result_o.last_of_packet  = (payload_left_q == sqd_pkg::LENGTH_BITS'(1));
      end else if (header_count_q != sqd_pkg::SEQ_BYTE_IDX) begin
        // little-endian length bytes
        case (header_count_q)
          2'd0:    length_accum_d = length_accum_q | byte_ext;
          2'd1:    length_accum_d = length_accum_q | (byte_ext << 8);
          default: length_accum_d = length_accum_q | (byte_ext << 16);
        endcase
        header_count_d = header_count_q + 2'd1;
      end else begin
        result_o.header_done    = 1'b1;
        result_o.packet_length  = len;
        result_o.packet_seq     = item_i.data_byte;
        result_o.protocol_error = ~match;
        result_o.last_of_packet = (len == '0);
        if (match) expected_seq_d = expected_seq_q + 8'd1;
        in_sync_d      = match;
        payload_left_d = sqd_pkg::LENGTH_BITS'(len);
        header_count_d = '0;
        length_accum_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_count_q <= '0;
      length_accum_q <= '0;
      payload_left_q <= '0;
      expected_seq_q <= '0;
      in_sync_q      <= 1'b0;
    end else if (accept_i) begin
      header_count_q <= header_count_d;
      length_accum_q <= length_accum_d;
      payload_left_q <= payload_left_d;
      expected_seq_q <= expected_seq_d;
      in_sync_q      <= in_sync_d;
    end
  end

endmodule

`default_nettype wire

### sv/sqd_out_reg.sv
// Result register of the deframer: holds one result until its transfer.
// Depends on sqd_pkg for the result type.
`default_nettype none

module sqd_out_reg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 load_i,
  input  sqd_pkg::out_item_t  result_i,
  input  wire                 ready_i,
  output logic                valid_o,
  output logic                free_o,
  output sqd_pkg::out_item_t  result_o
);

  logic               valid_q;
  sqd_pkg::out_item_t result_q;

  // free when empty or emptied by a transfer this cycle
  assign free_o   = ~valid_q | ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) result_q <= result_i;
  end

endmodule

`default_nettype wire

### dv/tb_seq_checked_packet_deframer.sv
// Self-checking testbench for seq_checked_packet_deframer: drives byte and resync
// transfers, predicts every result in-line and compares it field by field.
// Depends on sqd_pkg, sqd_if and the deframer RTL.
module tb_seq_checked_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  sqd_in_if  in_ch ();
  sqd_out_if out_ch ();

  seq_checked_packet_deframer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Deframer mirror state
  logic [2:0]                      hdr_count    = '0;
  logic [sqd_pkg::FIELD_BITS-1:0]  len_acc      = '0;
  logic [sqd_pkg::LENGTH_BITS-1:0] bytes_left   = '0;
  logic [7:0]                      seq_expected = '0;
  logic                            pkt_in_sync  = 1'b0;

  sqd_pkg::out_item_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_cycles_left = 0;
  logic [7:0]  gen_seq = '0;  // sequence the stimulus side believes is expected

  function automatic sqd_pkg::out_item_t deframe_step(input sqd_pkg::in_item_t it);
    sqd_pkg::out_item_t             r;
    logic [sqd_pkg::FIELD_BITS-1:0] len;
    r = '0;
    if (it.kind == sqd_pkg::KIND_RESYNC) begin
      seq_expected = it.new_expected_seq;
      return r;
    end
    r.out_byte = it.data_byte;
    if (bytes_left != 0) begin
      r.payload_valid   = pkt_in_sync;
      r.payload_skipped = !pkt_in_sync;
      bytes_left        = bytes_left - sqd_pkg::LENGTH_BITS'(1);
      r.last_of_packet  = (bytes_left == 0);
      return r;
    end
    if (hdr_count < 3'd3) begin
      len_acc   = len_acc | (sqd_pkg::FIELD_BITS'(it.data_byte) << (8 * hdr_count));
      hdr_count = hdr_count + 3'd1;
      return r;
    end
    // sequence byte closes the header
    len              = len_acc & sqd_pkg::LEN_MASK;
    r.header_done    = 1'b1;
    r.packet_length  = len;
    r.packet_seq     = it.data_byte;
    r.protocol_error = (it.data_byte != seq_expected);
    pkt_in_sync      = (it.data_byte == seq_expected);
    if (pkt_in_sync) seq_expected = seq_expected + 8'd1;
    bytes_left       = sqd_pkg::LENGTH_BITS'(len);
    r.last_of_packet = (len == 0);
    hdr_count        = '0;
    len_acc          = '0;
    return r;
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result(input sqd_pkg::out_item_t got);
    sqd_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, got out_byte %0h", $time,
               got.out_byte);
      error_count++;
      return;
    end
    want = pending_results.pop_front();
    check_field("out_byte",        want.out_byte,        got.out_byte);
    check_field("payload_valid",   want.payload_valid,   got.payload_valid);
    check_field("payload_skipped", want.payload_skipped, got.payload_skipped);
    check_field("header_done",     want.header_done,     got.header_done);
    check_field("packet_length",   want.packet_length,   got.packet_length);
    check_field("packet_seq",      want.packet_seq,      got.packet_seq);
    check_field("protocol_error",  want.protocol_error,  got.protocol_error);
    check_field("last_of_packet",  want.last_of_packet,  got.last_of_packet);
  endfunction

  // Predict on each input transfer, check on each output transfer.
  always @(posedge clk_i) begin : transfer_monitor
    sqd_pkg::in_item_t  it;
    sqd_pkg::out_item_t got;
    if (in_ch.valid && in_ch.ready) begin
      it.kind             = in_ch.kind;
      it.data_byte        = in_ch.data_byte;
      it.new_expected_seq = in_ch.new_expected_seq;
      pending_results.push_back(deframe_step(it));
    end
    if (out_ch.valid && out_ch.ready) begin
      got.out_byte        = out_ch.out_byte;
      got.payload_valid   = out_ch.payload_valid;
      got.payload_skipped = out_ch.payload_skipped;
      got.header_done     = out_ch.header_done;
      got.packet_length   = out_ch.packet_length;
      got.packet_seq      = out_ch.packet_seq;
      got.protocol_error  = out_ch.protocol_error;
      got.last_of_packet  = out_ch.last_of_packet;
      check_result(got);
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk_i) begin
    if (stall_cycles_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_cycles_left = stall_cycles_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input sqd_pkg::kind_e k, input logic [7:0] d,
                           input logic [7:0] s);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid            <= 1'b1;
    in_ch.kind             <= k;
    in_ch.data_byte        <= d;
    in_ch.new_expected_seq <= s;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(sqd_pkg::KIND_STREAM, b, 8'($urandom));
  endtask

  task automatic send_resync(input logic [7:0] s);
    send_item(sqd_pkg::KIND_RESYNC, 8'($urandom), s);
    gen_seq = s;
  endtask

  task automatic send_header(input logic [23:0] len, input logic [7:0] seq);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    send_byte(len[23:16]);
    send_byte(seq);
    if (seq == gen_seq) gen_seq = gen_seq + 8'd1;
  endtask

  task automatic test_directed;
    send_header(24'd0, 8'h00);           // zero-length, in sequence
    send_header(24'd2, 8'h01);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_resync(8'hFF);
    send_header(24'd1, 8'h55);           // out of sequence: payload skipped
    send_byte(8'hAA);
    send_header(24'd0, 8'hFF);           // expected wraps 255 -> 0
    send_header(24'd3, 8'h00);
    send_byte(8'h5A);
    send_resync(8'h80);                  // mid-packet resync keeps framing
    send_byte(8'hA5);
    send_byte(8'h3C);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned start;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  seq;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_resync(8'($urandom));
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(300, 40) : $urandom_range(12);
        seq = (pick < 80) ? gen_seq : 8'($urandom);
        send_header(24'(len), seq);
        repeat (len) begin
          if ($urandom_range(39) == 0) send_resync(8'($urandom));
          send_byte(8'($urandom));
        end
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering; input must stall.
  task automatic test_input_stall;
    int unsigned saved_idle;
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    stall_cycles_left = 150;
    send_header(24'd24, gen_seq);
    repeat (24) send_byte(8'($urandom));
    send_idle_pct = saved_idle;
  endtask

  // Longer packet so the middle length byte and wider counter bits see use.
  task automatic test_long_packet;
    send_header(24'h000140, gen_seq);
    repeat (24'h000140) send_byte(8'($urandom));
  endtask

  initial begin
    in_ch.valid            = 1'b0;
    in_ch.kind             = sqd_pkg::KIND_STREAM;
    in_ch.data_byte        = '0;
    in_ch.new_expected_seq = '0;
    out_ch.ready           = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 21;
    recv_idle_pct = 52;
    test_directed();
    test_random_traffic(220);
    test_input_stall();

    send_idle_pct = 52;
    recv_idle_pct = 21;
    test_random_traffic(220);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(220);
    test_long_packet();

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #6ms;
    $display("simulation failed");
    $finish;
  end

endmodule
